@@ rtl/two_link_leg_virtual_model_macros.svh @@
// Assertion helpers for the leg virtual model.
`ifndef TWO_LINK_LEG_VIRTUAL_MODEL_MACROS_SVH
`define TWO_LINK_LEG_VIRTUAL_MODEL_MACROS_SVH

// consequent in the same cycle
`define TLLVM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent in the next cycle
`define TLLVM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/tllvm_pkg.sv @@
`default_nettype none
package tllvm_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_TAB_LEN   = 24;
  localparam int DIV_QB           = 33;  // quotient bits of the divider

  typedef logic signed [35:0] ang_t;     // Q.30 radians

  localparam ang_t Q30_PI      = 36'sd3373259426;
  localparam ang_t Q30_TWO_PI  = 36'sd6746518852;
  localparam ang_t Q30_HALF_PI = 36'sd1686629713;
  localparam ang_t Q30_GAIN    = 36'sd652032874;

  localparam logic [15:0] LINK_LENGTH_RST = 16'd4588;
  localparam logic [15:0] STEP_TIME_RST   = 16'd1000;

  localparam logic REG_LINK_LENGTH = 1'b0;
  localparam logic REG_STEP_TIME   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WRAP, ST_FOLD, ST_CORDIC, ST_SINCOS,
    ST_MUL, ST_POST, ST_DIV_GO, ST_DIV_WAIT, ST_OUTPUT
  } state_t;

  typedef enum logic [2:0] {
    OP_LS, OP_LC, OP_LRATE, OP_TQ0, OP_TQ1, OP_ACC, OP_LF0A, OP_LF0B
  } mul_op_t;

  typedef enum logic [1:0] {DV_ACC, DV_LF0, DV_LF1} div_op_t;

  typedef struct packed {
    logic       load;
    logic       wrap;
    logic       fold;
    logic       cordic_step;
    logic [4:0] step_idx;
    logic       sincos;
    logic       mul;
    logic       post;
    mul_op_t    mul_op;
    logic       div_start;
    logic       div_store;
    div_op_t    div_op;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic singular;
  } dp_stat_t;

  function automatic ang_t atan_q30(input logic [4:0] idx);
    ang_t v;
    case (idx)
      5'd0:    v = 36'sh03243F6A8;
      5'd1:    v = 36'sh01DAC6705;
      5'd2:    v = 36'sh00FADBAFC;
      5'd3:    v = 36'sh007F56EA6;
      5'd4:    v = 36'sh003FEAB76;
      5'd5:    v = 36'sh001FFD55B;
      5'd6:    v = 36'sh000FFFAAA;
      5'd7:    v = 36'sh0007FFF55;
      5'd8:    v = 36'sh0003FFFEA;
      5'd9:    v = 36'sh0001FFFFD;
      5'd10:   v = 36'sh0000FFFFF;
      5'd11:   v = 36'sh00007FFFF;
      5'd12:   v = 36'sh00003FFFF;
      5'd13:   v = 36'sh00001FFFF;
      5'd14:   v = 36'sh00000FFFF;
      5'd15:   v = 36'sh000007FFF;
      5'd16:   v = 36'sh000003FFF;
      5'd17:   v = 36'sh000001FFF;
      5'd18:   v = 36'sh000000FFF;
      5'd19:   v = 36'sh0000007FF;
      5'd20:   v = 36'sh0000003FF;
      5'd21:   v = 36'sh0000001FF;
      5'd22:   v = 36'sh0000000FF;
      5'd23:   v = 36'sh00000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/tllvm_div.sv @@
`default_nettype none
// Signed divide, round to nearest (ties away from zero).
// Returns magnitude, sign and an overflow flag when the quotient exceeds DIV_QB bits.
module tllvm_div (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic signed [63:0]                  num,
  input  wire logic signed [38:0]                  den,
  output logic                                     done,
  output logic [tllvm_pkg::DIV_QB-1:0]             q_mag,
  output logic                                     ovf,
  output logic                                     neg
);
  localparam int QB = tllvm_pkg::DIV_QB;

  logic          busy_r;
  logic [5:0]    cnt_r;
  logic          done_r;
  logic [63:0]   un_r;
  logic [37:0]   ud_r;
  logic          neg_r;
  logic          ovf_r;
  logic [37:0]   rem_r;
  logic [QB-1:0] low_r;

  logic [63:0] n_sum;
  logic [38:0] t_val;
  logic        ge;
  logic [63:0] num_abs;
  logic [38:0] den_abs;

  always_comb begin
    num_abs = num[63] ? 64'(-num) : 64'(num);
    den_abs = den[38] ? 39'(-den) : 39'(den);
    n_sum   = un_r + {26'b0, ud_r >> 1};
    t_val   = {rem_r, low_r[QB-1]};
    ge      = t_val >= {1'b0, ud_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (start) begin
          busy_r <= 1'b1;
          cnt_r  <= '0;
        end
      end else begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(QB)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r) begin
      if (start) begin
        un_r  <= num_abs;
        ud_r  <= den_abs[37:0];
        neg_r <= num[63] ^ den[38];
      end
    end else if (cnt_r == 6'd0) begin
      ovf_r <= {7'b0, n_sum[63:QB]} >= ud_r;
      rem_r <= 38'(n_sum[63:QB]);
      low_r <= n_sum[QB-1:0];
    end else begin
      rem_r <= ge ? 38'(t_val - {1'b0, ud_r}) : t_val[37:0];
      low_r <= {low_r[QB-2:0], ge};
    end
  end

  assign done  = done_r;
  assign q_mag = low_r;
  assign ovf   = ovf_r;
  assign neg   = neg_r;
endmodule
`default_nettype wire

@@ rtl/tllvm_ctrl.sv @@
`default_nettype none
module tllvm_ctrl #(
  parameter int CORDIC_STEPS = tllvm_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  input  wire tllvm_pkg::dp_stat_t stat,
  output tllvm_pkg::dp_cmd_t       cmd
);
  localparam int NSTEPS = (CORDIC_STEPS < tllvm_pkg::CORDIC_TAB_LEN) ?
                          CORDIC_STEPS : tllvm_pkg::CORDIC_TAB_LEN;
  localparam logic [4:0] LAST_STEP = 5'(NSTEPS - 1);

  tllvm_pkg::state_t state_r, state_nxt;
  logic [4:0] step_r, step_nxt;
  logic [2:0] op_r, op_nxt;
  logic [1:0] dv_r, dv_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_fire;

  assign out_fire = (state_r == tllvm_pkg::ST_OUTPUT) && (!out_valid_r || out_tready);

  // next state and counters
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    op_nxt    = op_r;
    dv_nxt    = dv_r;
    case (state_r)
      tllvm_pkg::ST_IDLE: begin
        step_nxt = '0;
        op_nxt   = '0;
        dv_nxt   = '0;
        if (in_tvalid) state_nxt = tllvm_pkg::ST_WRAP;
      end
      tllvm_pkg::ST_WRAP: state_nxt = tllvm_pkg::ST_FOLD;
      tllvm_pkg::ST_FOLD: state_nxt = tllvm_pkg::ST_CORDIC;
      tllvm_pkg::ST_CORDIC: begin
        step_nxt = step_r + 5'd1;
        if (step_r == LAST_STEP) state_nxt = tllvm_pkg::ST_SINCOS;
      end
      tllvm_pkg::ST_SINCOS: state_nxt = tllvm_pkg::ST_MUL;
      tllvm_pkg::ST_MUL: state_nxt = tllvm_pkg::ST_POST;
      tllvm_pkg::ST_POST: begin
        op_nxt = op_r + 3'd1;
        if (tllvm_pkg::mul_op_t'(op_r) == tllvm_pkg::OP_LF0B) state_nxt = tllvm_pkg::ST_DIV_GO;
        else state_nxt = tllvm_pkg::ST_MUL;
      end
      tllvm_pkg::ST_DIV_GO: state_nxt = tllvm_pkg::ST_DIV_WAIT;
      tllvm_pkg::ST_DIV_WAIT: begin
        if (stat.div_done) begin
          dv_nxt = dv_r + 2'd1;
          if ((tllvm_pkg::div_op_t'(dv_r) == tllvm_pkg::DV_LF1) ||
              (tllvm_pkg::div_op_t'(dv_r) == tllvm_pkg::DV_ACC && stat.singular)) begin
            state_nxt = tllvm_pkg::ST_OUTPUT;
          end else begin
            state_nxt = tllvm_pkg::ST_DIV_GO;
          end
        end
      end
      tllvm_pkg::ST_OUTPUT: if (out_fire) state_nxt = tllvm_pkg::ST_IDLE;
      default: state_nxt = tllvm_pkg::ST_IDLE;
    endcase
    out_valid_nxt = out_valid_r && !out_tready;
    if (out_fire) out_valid_nxt = 1'b1;
  end

  // command outputs
  always_comb begin
    cmd             = '0;
    cmd.step_idx    = step_r;
    cmd.mul_op      = tllvm_pkg::mul_op_t'(op_r);
    cmd.div_op      = tllvm_pkg::div_op_t'(dv_r);
    cmd.load        = (state_r == tllvm_pkg::ST_IDLE) && in_tvalid;
    cmd.wrap        = state_r == tllvm_pkg::ST_WRAP;
    cmd.fold        = state_r == tllvm_pkg::ST_FOLD;
    cmd.cordic_step = state_r == tllvm_pkg::ST_CORDIC;
    cmd.sincos      = state_r == tllvm_pkg::ST_SINCOS;
    cmd.mul         = state_r == tllvm_pkg::ST_MUL;
    cmd.post        = state_r == tllvm_pkg::ST_POST;
    cmd.div_start   = state_r == tllvm_pkg::ST_DIV_GO;
    cmd.div_store   = (state_r == tllvm_pkg::ST_DIV_WAIT) && stat.div_done;
    cmd.out_load    = out_fire;
    in_tready       = state_r == tllvm_pkg::ST_IDLE;
    out_tvalid      = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tllvm_pkg::ST_IDLE;
      step_r      <= '0;
      op_r        <= '0;
      dv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      op_r        <= op_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule
`default_nettype wire

@@ rtl/tllvm_dp.sv @@
`default_nettype none
module tllvm_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr,
  input  wire logic                cfg_index,
  input  wire logic [15:0]         cfg_data,
  input  wire logic [159:0]        in_tdata,
  input  wire tllvm_pkg::dp_cmd_t  cmd,
  output tllvm_pkg::dp_stat_t      stat,
  output logic [199:0]             out_tdata,
  output logic                     out_tuser
);
  typedef logic signed [63:0] s64_t;

  function automatic s64_t rshr(input s64_t v, input int unsigned sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic s64_t sat(input s64_t v, input s64_t lo, input s64_t hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic tllvm_pkg::ang_t wrap_pi(input tllvm_pkg::ang_t a);
    tllvm_pkg::ang_t r;
    r = a;
    if (a > tllvm_pkg::Q30_PI) r = a - tllvm_pkg::Q30_TWO_PI;
    else if (a < -tllvm_pkg::Q30_PI) r = a + tllvm_pkg::Q30_TWO_PI;
    return r;
  endfunction

  // config and history
  logic [15:0]        link_r, step_time_r;
  logic signed [15:0] last_rate_r;

  // item fields
  logic signed [15:0] ta_r, tb_r, ra_r, rb_r;
  logic signed [23:0] f0_r, f1_r, m0_r, m1_r;

  tllvm_pkg::ang_t dw_r, pw_r, x_r, y_r, z_r, s_r, c_r;
  logic               neg_r;
  logic signed [14:0] phi_r;
  logic signed [15:0] rate_r;
  logic signed [62:0] p_r, tmp_r;
  logic signed [37:0] jb_r, jd_r;
  logic signed [38:0] det_r;
  logic               sing_r;
  logic signed [19:0] len_r;
  logic signed [18:0] lrate_r;
  logic signed [23:0] tq0_r, tq1_r, lf0_r, lf1_r;
  logic signed [31:0] acc_r;
  s64_t               num_acc_r, num_lf0_r;
  logic [199:0]       out_data_r;
  logic               out_sing_r;

  // combinational terms
  logic signed [16:0] dang, sang, rsum, rdiff, lrd;
  tllvm_pkg::ang_t    d_raw, s_raw, d_fold, dx, dy, atan_v;
  logic               fold_neg;
  s64_t               phi_w, p64, r15, r28, v_lr, v_tq;
  logic signed [37:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [39:0] det_w;
  s64_t               div_num;
  logic signed [38:0] div_den;
  logic [15:0]        dt;
  logic               dv_done, dv_ovf, dv_neg;
  logic [tllvm_pkg::DIV_QB-1:0] dv_mag, mag_s;
  logic signed [34:0] qs;

  always_comb begin
    dang  = {tb_r[15], tb_r} - {ta_r[15], ta_r};
    sang  = {ta_r[15], ta_r} + {tb_r[15], tb_r};
    rsum  = {ra_r[15], ra_r} + {rb_r[15], rb_r};
    rdiff = {rb_r[15], rb_r} - {ra_r[15], ra_r};
    lrd   = {rsum[16], rsum[16:1]} - {last_rate_r[15], last_rate_r};
    d_raw = {{2{dang[16]}}, dang, 17'b0};
    s_raw = {{2{sang[16]}}, sang, 17'b0};

    // fold into [-pi/2, pi/2] with a half turn
    fold_neg = 1'b0;
    d_fold   = dw_r;
    if (dw_r > tllvm_pkg::Q30_HALF_PI) begin
      d_fold   = dw_r - tllvm_pkg::Q30_PI;
      fold_neg = 1'b1;
    end else if (dw_r < -tllvm_pkg::Q30_HALF_PI) begin
      d_fold   = dw_r + tllvm_pkg::Q30_PI;
      fold_neg = 1'b1;
    end
    phi_w = sat(rshr(64'(pw_r), 18), -64'sd12868, 64'sd12868);

    dx     = y_r >>> cmd.step_idx;
    dy     = x_r >>> cmd.step_idx;
    atan_v = tllvm_pkg::atan_q30(cmd.step_idx);

    // shared multiplier operands
    mul_a = {{2{s_r[35]}}, s_r};
    mul_b = {9'b0, link_r};
    case (cmd.mul_op)
      tllvm_pkg::OP_LS:    begin mul_a = {{2{s_r[35]}}, s_r}; mul_b = {9'b0, link_r}; end
      tllvm_pkg::OP_LC:    begin mul_a = {{2{c_r[35]}}, c_r}; mul_b = {9'b0, link_r}; end
      tllvm_pkg::OP_LRATE: begin mul_a = jb_r; mul_b = 25'(rdiff); end
      tllvm_pkg::OP_TQ0:   begin mul_a = jb_r; mul_b = 25'(f1_r); end
      tllvm_pkg::OP_TQ1:   begin mul_a = jd_r; mul_b = 25'(f1_r); end
      tllvm_pkg::OP_ACC:   begin mul_a = 38'(lrd); mul_b = 25'sd1000000; end
      tllvm_pkg::OP_LF0A:  begin mul_a = jd_r; mul_b = 25'(m0_r); end
      tllvm_pkg::OP_LF0B:  begin mul_a = jb_r; mul_b = 25'(m1_r); end
      default:             begin mul_a = '0; mul_b = '0; end
    endcase

    p64   = 64'(p_r);
    r15   = rshr(p64, 15);
    r28   = sat(rshr(p64, 28), -64'sd262144, 64'sd262144);
    v_lr  = sat(rshr(-p64, 30), -64'sd131072, 64'sd131072);
    v_tq  = sat(rshr((64'(f0_r) <<< 29) + p64, 30), -64'sd8388608, 64'sd8388607);
    det_w = ($signed({{2{jd_r[37]}}, jd_r}) - $signed({{2{jb_r[37]}}, jb_r}) + 40'sd1) >>> 1;

    dt = (step_time_r == 16'd0) ? 16'd1 : step_time_r;
    case (cmd.div_op)
      tllvm_pkg::DV_ACC: begin div_num = num_acc_r; div_den = $signed({23'b0, dt}); end
      tllvm_pkg::DV_LF0: begin div_num = num_lf0_r; div_den = det_r; end
      tllvm_pkg::DV_LF1: begin
        div_num = (64'(m1_r) - 64'(m0_r)) <<< 29;
        div_den = det_r;
      end
      default:           begin div_num = '0; div_den = 39'sd1; end
    endcase

    mag_s = dv_ovf ? '1 : dv_mag;
    qs    = dv_neg ? -$signed({2'b0, mag_s}) : $signed({2'b0, mag_s});
  end

  tllvm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (dv_done),
    .q_mag (dv_mag),
    .ovf   (dv_ovf),
    .neg   (dv_neg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r      <= tllvm_pkg::LINK_LENGTH_RST;
      step_time_r <= tllvm_pkg::STEP_TIME_RST;
      last_rate_r <= '0;
    end else begin
      if (cfg_wr) begin
        if (cfg_index == tllvm_pkg::REG_LINK_LENGTH) link_r <= cfg_data;
        else step_time_r <= cfg_data;
      end
      if (cmd.out_load) last_rate_r <= rate_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ta_r <= in_tdata[15:0];    tb_r <= in_tdata[31:16];
      ra_r <= in_tdata[47:32];   rb_r <= in_tdata[63:48];
      f0_r <= in_tdata[87:64];   f1_r <= in_tdata[111:88];
      m0_r <= in_tdata[135:112]; m1_r <= in_tdata[159:136];
    end
    if (cmd.wrap) begin
      dw_r   <= wrap_pi(d_raw);
      pw_r   <= wrap_pi(s_raw);
      rate_r <= rsum[16:1];
    end
    if (cmd.fold) begin
      x_r   <= tllvm_pkg::Q30_GAIN;
      y_r   <= '0;
      z_r   <= d_fold;
      neg_r <= fold_neg;
      phi_r <= phi_w[14:0];
    end
    if (cmd.cordic_step) begin
      if (!z_r[35]) begin
        x_r <= x_r - dx; y_r <= y_r + dy; z_r <= z_r - atan_v;
      end else begin
        x_r <= x_r + dx; y_r <= y_r - dy; z_r <= z_r + atan_v;
      end
    end
    if (cmd.sincos) begin
      s_r <= neg_r ? -y_r : y_r;
      c_r <= neg_r ? -x_r : x_r;
    end
    if (cmd.mul) p_r <= mul_a * mul_b;
    if (cmd.post) begin
      case (cmd.mul_op)
        tllvm_pkg::OP_LS:    jb_r <= r15[37:0];
        tllvm_pkg::OP_LC: begin
          jd_r  <= -r15[37:0];
          len_r <= r28[19:0];
        end
        tllvm_pkg::OP_LRATE: lrate_r <= v_lr[18:0];
        tllvm_pkg::OP_TQ0:   tq0_r <= v_tq[23:0];
        tllvm_pkg::OP_TQ1:   tq1_r <= v_tq[23:0];
        tllvm_pkg::OP_ACC:   num_acc_r <= p64;
        tllvm_pkg::OP_LF0A: begin
          tmp_r  <= p_r;
          det_r  <= det_w[38:0];
          sing_r <= det_w == 40'sd0;
          lf0_r  <= '0;
          lf1_r  <= '0;
        end
        tllvm_pkg::OP_LF0B:  num_lf0_r <= 64'(tmp_r) - p64;
        default: ;
      endcase
    end
    if (cmd.div_store) begin
      case (cmd.div_op)
        tllvm_pkg::DV_ACC: acc_r <= 32'(sat(64'(qs), -64'sd2147483648, 64'sd2147483647));
        tllvm_pkg::DV_LF0: lf0_r <= 24'(sat(64'(qs), -64'sd8388608, 64'sd8388607));
        tllvm_pkg::DV_LF1: lf1_r <= 24'(sat(64'(qs), -64'sd8388608, 64'sd8388607));
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      out_data_r <= {2'b0, lf1_r, lf0_r, tq1_r, tq0_r, acc_r, lrate_r, rate_r, len_r, phi_r};
      out_sing_r <= sing_r;
    end
  end

  assign stat.div_done = dv_done;
  assign stat.singular = sing_r;
  assign out_tdata     = out_data_r;
  assign out_tuser     = out_sing_r;
endmodule
`default_nettype wire

@@ rtl/two_link_leg_virtual_model.sv @@
`default_nettype none
// Two-link leg virtual model: per item it turns two joint angles and rates, a virtual force
// pair and a measured torque pair into leg angle, leg length, their rates, leg angle
// acceleration, joint torques J^T*F and leg forces inv(J^T)*torque, all saturated. Items are
// handled one at a time: in_tready is high only while the block is idle, and a finished
// result sits in the output register so the next item can be taken while it waits. Each item
// runs three divisions, or one when the leg is singular, and is held back while a full output
// register is not taken; its pace is set by the single CORDIC stage (one step per cycle, at most
// 24 steps), the shared 38x25 multiplier (eight products) and the one bit-per-cycle divider.
// Registers: index 0 link_length (Q0.16 metres), index 1 step_time_us (0 is taken as 1);
// write only when idle. singular rides on out_tuser and forces the leg forces to zero.
`include "two_link_leg_virtual_model_macros.svh"
module two_link_leg_virtual_model #(
  parameter int CORDIC_STEPS = tllvm_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // config write
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic         cfg_index,
  input  wire logic [15:0]  cfg_data,
  // input item
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // angle_a, angle_b, rate_a, rate_b (16 each), virtual_force_0, virtual_force_1,
  // motor_torque_0, motor_torque_1 (24 each), from bit 0 up
  input  wire logic [159:0] in_tdata,
  // result item
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // leg_angle (15), leg_len (20), leg_angle_rate (16), leg_len_rate (19),
  // leg_angle_accel (32), joint_torque_0/1, leg_force_0/1 (24 each), 2 pad bits, from bit 0 up
  output logic [199:0]      out_tdata,
  // singular
  output logic              out_tuser
);
  localparam logic signed [14:0] PHI_MAX = 15'sd12868;

  tllvm_pkg::dp_cmd_t  cmd;
  tllvm_pkg::dp_stat_t stat;
  logic signed [14:0]  phi_out;
  logic [47:0]         force_bits;

  // registers take a write any cycle
  assign cfg_ready = 1'b1;

  tllvm_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  tllvm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  assign phi_out    = out_tdata[14:0];
  assign force_bits = out_tdata[197:150];

  // an accepted item keeps the block busy for at least the next cycle
  `TLLVM_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "accept while busy")
  // singular leg gives zero leg forces
  `TLLVM_ASSERT_NOW(a_sing_zero, out_tvalid && out_tuser, force_bits == 48'd0, "forces not zero")
  // leg angle stays within its wrap range
  `TLLVM_ASSERT_NOW(a_phi_range, out_tvalid, (phi_out <= PHI_MAX) && (phi_out >= -PHI_MAX), "phi")
endmodule
`default_nettype wire

@@ tb/sv/tb_two_link_leg_virtual_model.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tb_two_link_leg_virtual_model;

  localparam longint PI_Q30     = 64'sd3373259426;
  localparam longint TWO_PI_Q30 = 64'sd6746518852;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint GAIN_Q30   = 64'sd652032874;
  localparam longint HALF_Q30   = 64'sd536870912;
  localparam int     N_STEPS    = 16;
  localparam int     N_RANDOM   = 400;

  // one input item, fields in packing order
  typedef struct {
    logic signed [15:0] ang_a, ang_b, vel_a, vel_b;
    logic signed [23:0] vf0, vf1, mt0, mt1;
  } leg_in_t;

  // one leg state result
  typedef struct packed {
    logic [14:0] phi;
    logic [19:0] len;
    logic [15:0] phi_rate;
    logic [18:0] len_rate;
    logic [31:0] phi_acc;
    logic [23:0] tq0, tq1, lf0, lf1;
    logic        sing;
  } leg_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = tllvm_pkg::REG_LINK_LENGTH;
  logic [15:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [159:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [199:0] out_tdata;
  logic out_tuser;

  two_link_leg_virtual_model u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial forever #2 clk = ~clk;

  // predictor state and register copies
  longint link_len = 4588;
  longint step_us = 1000;
  longint prev_rate = 0;

  leg_in_t  pending_items[$];
  leg_out_t expected_legs[$];
  int n_fail = 0;
  int n_seen = 0;
  int n_sing = 0;
  bit hold_out = 1'b0;   // long receiver hold-off
  bit pause_in = 1'b0;   // sender waits for drain

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;   // arithmetic shift floors
  endfunction

  function automatic longint round_shr(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // nearest, ties away from zero
  function automatic longint div_round(longint num, longint den);
    longint un, ud, q;
    un = num < 0 ? -num : num;
    ud = den < 0 ? -den : den;
    q = (un + ud / 2) / ud;
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic longint wrap_angle(longint a);
    while (a > PI_Q30) a -= TWO_PI_Q30;
    while (a < -PI_Q30) a += TWO_PI_Q30;
    return a;
  endfunction

  function automatic longint atan_entry(int i);
    longint tab[24] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
      64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
      64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
    return tab[i];
  endfunction

  task automatic half_angle_sincos(input longint ang, output longint s, output longint c);
    longint x, y, z, dx, dy;
    bit flip;
    x = GAIN_Q30; y = 0; flip = 1'b0;
    ang = wrap_angle(ang);
    // fold into the right half plane, a half turn negates both
    if (ang > HALF_PI_Q30) begin
      ang -= PI_Q30; flip = 1'b1;
    end else if (ang < -HALF_PI_Q30) begin
      ang += PI_Q30; flip = 1'b1;
    end
    z = ang;
    for (int i = 0; i < N_STEPS && i < 24; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_entry(i);
      end else begin
        x += dx; y -= dy; z += atan_entry(i);
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endtask

  task automatic predict_leg(input leg_in_t it, output leg_out_t r);
    longint ta, tb, ra, rb, f0, f1, m0, m1, s, c, ls, lc, jb, jd, det, rate, dt;
    ta = it.ang_a; tb = it.ang_b; ra = it.vel_a; rb = it.vel_b;
    f0 = it.vf0; f1 = it.vf1; m0 = it.mt0; m1 = it.mt1;
    dt = step_us == 0 ? 1 : step_us;
    half_angle_sincos((tb - ta) * 131072, s, c);
    ls = link_len * s;
    lc = link_len * c;
    jb = round_shr(ls, 15);
    jd = -round_shr(lc, 15);
    r.phi = 15'(clip(round_shr(wrap_angle((ta + tb) * 131072), 18), -12868, 12868));
    r.len = 20'(clip(round_shr(lc, 28), -262144, 262144));
    rate = floor_shr(ra + rb, 1);
    r.phi_rate = 16'(rate);
    r.len_rate = 19'(clip(round_shr(-(jb * (rb - ra)), 30), -131072, 131072));
    r.phi_acc = 32'(clip(div_round((rate - prev_rate) * 1000000, dt),
                         -64'sd2147483648, 64'sd2147483647));
    prev_rate = rate;
    r.tq0 = 24'(clip(round_shr(f0 * HALF_Q30 + jb * f1, 30), -8388608, 8388607));
    r.tq1 = 24'(clip(round_shr(f0 * HALF_Q30 + jd * f1, 30), -8388608, 8388607));
    det = round_shr(jd - jb, 1);
    if (det == 0) begin
      r.sing = 1'b1; r.lf0 = '0; r.lf1 = '0;
    end else begin
      r.sing = 1'b0;
      r.lf0 = 24'(clip(div_round(jd * m0 - jb * m1, det), -8388608, 8388607));
      r.lf1 = 24'(clip(div_round((m1 - m0) * HALF_Q30, det), -8388608, 8388607));
    end
  endtask

  function automatic logic [159:0] pack_item(leg_in_t it);
    return {it.mt1, it.mt0, it.vf1, it.vf0, it.vel_b, it.vel_a, it.ang_b, it.ang_a};
  endfunction

  function automatic leg_in_t rand_item();
    leg_in_t it;
    it.ang_a = 16'($urandom); it.ang_b = 16'($urandom);
    it.vel_a = 16'($urandom); it.vel_b = 16'($urandom);
    it.vf0 = 24'($urandom); it.vf1 = 24'($urandom);
    it.mt0 = 24'($urandom); it.mt1 = 24'($urandom);
    // often keep magnitudes modest so saturation does not swamp the arithmetic
    if ($urandom_range(0, 2) != 0) begin
      it.vf0 = 24'(signed'(it.vf0) >>> $urandom_range(0, 12));
      it.vf1 = 24'(signed'(it.vf1) >>> $urandom_range(0, 12));
      it.mt0 = 24'(signed'(it.mt0) >>> $urandom_range(0, 12));
      it.mt1 = 24'(signed'(it.mt1) >>> $urandom_range(0, 12));
    end
    return it;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    return ($urandom_range(0, 15) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
  endfunction

  // Driver: takes the oldest pending item, holds it until accepted.
  // Prediction happens at the accepting edge so it follows any register writes.
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        leg_out_t exp_r;
        predict_leg(pending_items.pop_front(), exp_r);
        expected_legs.push_back(exp_r);
        in_gap = gap_len();
      end
      if ((!in_tvalid || in_tready) ) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() > 0 && !pause_in) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pack_item(pending_items[0]);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction.
  int out_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        leg_out_t got, exp_r;
        got.phi = out_tdata[14:0];
        got.len = out_tdata[34:15];
        got.phi_rate = out_tdata[50:35];
        got.len_rate = out_tdata[69:51];
        got.phi_acc = out_tdata[101:70];
        got.tq0 = out_tdata[125:102];
        got.tq1 = out_tdata[149:126];
        got.lf0 = out_tdata[173:150];
        got.lf1 = out_tdata[197:174];
        got.sing = out_tuser;
        n_seen++;
        if (expected_legs.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) $display("unexpected result item %0d", n_seen);
        end else begin
          exp_r = expected_legs.pop_front();
          n_sing += exp_r.sing;
          if (got !== exp_r) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("mismatch item %0d", n_seen);
              $display("  exp phi=%h len=%h rate=%h lrate=%h acc=%h tq=%h/%h lf=%h/%h s=%b",
                       exp_r.phi, exp_r.len, exp_r.phi_rate, exp_r.len_rate, exp_r.phi_acc,
                       exp_r.tq0, exp_r.tq1, exp_r.lf0, exp_r.lf1, exp_r.sing);
              $display("  got phi=%h len=%h rate=%h lrate=%h acc=%h tq=%h/%h lf=%h/%h s=%b",
                       got.phi, got.len, got.phi_rate, got.len_rate, got.phi_acc,
                       got.tq0, got.tq1, got.lf0, got.lf1, got.sing);
            end
          end
        end
        out_gap = gap_len();
      end
      if (hold_out) begin
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off, counted in its own process.
  initial begin
    wait (rst_n);
    repeat (3000) @(posedge clk);
    hold_out <= 1'b1;
    repeat (2000) @(posedge clk);
    hold_out <= 1'b0;
  end

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == tllvm_pkg::REG_LINK_LENGTH) link_len = val;
    else step_us = val;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || expected_legs.size() > 0 || in_tvalid)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic add_item(input logic signed [15:0] a, b, va, vb,
                          input logic signed [23:0] f0, f1, m0, m1);
    leg_in_t it;
    it.ang_a = a; it.ang_b = b; it.vel_a = va; it.vel_b = vb;
    it.vf0 = f0; it.vf1 = f1; it.mt0 = m0; it.mt1 = m1;
    pending_items.push_back(it);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, angle wrap at +-pi, folding
    add_item(0, 0, 0, 0, 0, 0, 0, 0);
    add_item(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
             24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    add_item(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000,
             -24'sh800000, -24'sh800000, -24'sh800000, -24'sh800000);
    add_item(-16'sh8000, 16'sh7FFF, 16'sh7FFF, -16'sh8000,
             24'sh7FFFFF, -24'sh800000, -24'sh800000, 24'sh7FFFFF);
    add_item(12868, 12868, 100, -100, 1000, -1000, 5000, -5000);
    add_item(0, 12868, 256, 0, 256, 256, 256, 256);       // d near pi/2
    add_item(0, 25736, -256, 256, 256, -256, 512, 512);   // d near pi
    add_item(6434, -6434, 3, 4, 9999, 1, -1, 77);
    add_item(-3217, 3217, -1, -2, 1, 1, 1, 1);
    add_item(0, 6434, 0, 0, 4096, 4096, 4096, -4096);
    drain();

    // zero link length makes the leg singular; step time at its extremes
    write_reg(tllvm_pkg::REG_LINK_LENGTH, 16'd0);
    write_reg(tllvm_pkg::REG_STEP_TIME, 16'd0);
    add_item(100, 200, 16'sh7FFF, 16'sh7FFF, 500, 500, 500, 500);
    add_item(100, 200, -16'sh8000, -16'sh8000, 500, 500, 500, 500);
    add_item(0, 0, 0, 0, 24'sh7FFFFF, 24'sh7FFFFF, 1, 2);
    drain();
    write_reg(tllvm_pkg::REG_LINK_LENGTH, 16'hFFFF);
    write_reg(tllvm_pkg::REG_STEP_TIME, 16'hFFFF);
    add_item(0, 0, 16'sh7FFF, 0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, -24'sh800000);
    add_item(0, 12868, -16'sh8000, 0, -24'sh800000, 24'sh7FFFFF, 3, -3);
    add_item(-12868, 12868, 0, 0, 10, 10, 10, 10);
    drain();

    // random phases across several register settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(tllvm_pkg::REG_LINK_LENGTH, 16'd4588);
          write_reg(tllvm_pkg::REG_STEP_TIME, 16'd1000);
        end
        1: begin
          write_reg(tllvm_pkg::REG_LINK_LENGTH, 16'd1);
          write_reg(tllvm_pkg::REG_STEP_TIME, 16'd1);
        end
        2: begin
          write_reg(tllvm_pkg::REG_LINK_LENGTH, 16'($urandom));
          write_reg(tllvm_pkg::REG_STEP_TIME, 16'($urandom));
        end
        default: begin
          write_reg(tllvm_pkg::REG_LINK_LENGTH, 16'hFFFF);
          write_reg(tllvm_pkg::REG_STEP_TIME, 16'd1000);
        end
      endcase
      for (int k = 0; k < N_RANDOM / 4; k++) begin
        pending_items.push_back(rand_item());
        if (ph == 1 && k == 50) begin
          // sender pauses until every expected result has come
          while (pending_items.size() > 0 || in_tvalid) @(posedge clk);
          pause_in = 1'b1;
          while (expected_legs.size() > 0) @(posedge clk);
          pause_in = 1'b0;
        end
      end
      drain();
    end

    $display("Covered %0d result items (%0d singular) over six link length / step time settings,",
             n_seen, n_sing);
    $display("including field extremes, angle wrap, long output stall and an input pause.");
    if (n_fail == 0 && expected_legs.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d failures", n_fail + expected_legs.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
+incdir+rtl
rtl/tllvm_pkg.sv
rtl/tllvm_div.sv
rtl/tllvm_ctrl.sv
rtl/tllvm_dp.sv
rtl/two_link_leg_virtual_model.sv
tb/sv/tb_two_link_leg_virtual_model.sv
